// ----- src/tccq_pkg.sv -----
package tccq_pkg;

  localparam int unsigned RATE_FIFO_DEPTH_DEF = 16;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned POS_W    = 48;
  localparam int unsigned TGT_W    = 32;
  localparam int unsigned BLK_W    = 24;
  localparam int unsigned PEND_W   = 5;
  localparam int unsigned ENTRY_W  = 2 * TAG_W + POS_W + TGT_W;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_RATE    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREQ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CONSUME = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_FSET,
    ST_RD,
    ST_CHK,
    ST_FRQ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;  // latch item fields, clear result regs
    logic push;    // append rate entry
    logic fset;    // overwrite frequency slot
    logic chk;     // evaluate FIFO head
    logic frq;     // evaluate frequency slot
  } cmd_t;

  typedef struct packed {
    logic empty;   // FIFO holds no entry
    logic last;    // FIFO holds exactly one entry
    logic stop;    // head entry is matching and in the future
  } sts_t;

endpackage

// ----- src/tccq_ram.sv -----
module tccq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/tccq_ctrl.sv -----
module tccq_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [tccq_pkg::FUNC_W-1:0]         func_i,
  input  tccq_pkg::sts_t                      sts_i,
  output tccq_pkg::cmd_t                      cmd_o,
  output logic                                busy_o,
  output logic                                done_o
);
  import tccq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != ST_IDLE);
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          case (func_i)
            FUNC_RATE:    state_d = ST_PUSH;
            FUNC_FREQ:    state_d = ST_FSET;
            FUNC_CONSUME: state_d = sts_i.empty ? ST_FRQ : ST_RD;
            default:      state_d = ST_DONE;
          endcase
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = ST_DONE;
      end
      ST_FSET: begin
        cmd_o.fset = 1'b1;
        state_d    = ST_DONE;
      end
      ST_RD: begin
        state_d = ST_CHK;  // head read in flight
      end
      ST_CHK: begin
        cmd_o.chk = 1'b1;
        if (sts_i.stop || sts_i.last) begin
          state_d = ST_FRQ;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_FRQ: begin
        cmd_o.frq = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/tccq_dp.sv -----
module tccq_dp #(
  parameter int unsigned RATE_FIFO_DEPTH = tccq_pkg::RATE_FIFO_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tccq_pkg::cmd_t                     cmd_i,
  output tccq_pkg::sts_t                     sts_o,
  input  logic [tccq_pkg::FUNC_W-1:0]        func_i,
  input  logic [tccq_pkg::TAG_W-1:0]         gen_tag_i,
  input  logic [tccq_pkg::TAG_W-1:0]         epoch_tag_i,
  input  logic [tccq_pkg::POS_W-1:0]         sample_pos_i,
  input  logic signed [tccq_pkg::TGT_W-1:0]  target_value_i,
  input  logic [tccq_pkg::BLK_W-1:0]         max_block_i,
  output logic [tccq_pkg::BLK_W-1:0]         block_samples_o,
  output logic                               rate_due_o,
  output logic signed [tccq_pkg::TGT_W-1:0]  rate_target_o,
  output logic                               freq_due_o,
  output logic signed [tccq_pkg::TGT_W-1:0]  freq_target_o,
  output logic [tccq_pkg::PEND_W-1:0]        rate_pending_o,
  output logic                               freq_pending_o,
  output logic                               push_dropped_o
);
  import tccq_pkg::*;

  localparam int unsigned HW = $clog2(RATE_FIFO_DEPTH);
  localparam int unsigned CW = $clog2(RATE_FIFO_DEPTH + 1);

  // latched item
  logic [2*TAG_W-1:0] tags_q;
  logic [POS_W-1:0]   pos_q;
  logic [TGT_W-1:0]   tgt_q;

  // FIFO control
  logic [HW-1:0] head_q;
  logic [CW-1:0] count_q;

  // frequency slot
  logic               fvalid_q;
  logic [2*TAG_W-1:0] ftags_q;
  logic [POS_W-1:0]   ftime_q;
  logic [TGT_W-1:0]   ftgt_q;

  // result regs
  logic [BLK_W-1:0] blk_q;
  logic             rdue_q, fdue_q, dropped_q;
  logic [TGT_W-1:0] rtgt_q, ftgt_out_q;

  logic [ENTRY_W-1:0] rd_entry;
  logic [2*TAG_W-1:0] h_tags;
  logic [POS_W-1:0]   h_time;
  logic [TGT_W-1:0]   h_tgt;
  logic               h_miss, h_due;
  logic [POS_W-1:0]   h_dist, f_dist;
  logic [CW:0]        tail_sum;
  logic [HW-1:0]      tail;
  logic [HW-1:0]      head_nxt;
  logic               full;
  logic [CW+PEND_W-1:0] cnt_ext;

  assign h_tags = rd_entry[ENTRY_W-1 -: 2*TAG_W];
  assign h_time = rd_entry[POS_W+TGT_W-1 -: POS_W];
  assign h_tgt  = rd_entry[TGT_W-1:0];
  assign h_miss = (h_tags != tags_q);
  assign h_due  = (h_time <= pos_q);
  assign h_dist = h_time - pos_q;
  assign f_dist = ftime_q - pos_q;

  assign tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
  always_comb begin
    if (tail_sum >= (CW+1)'(RATE_FIFO_DEPTH)) begin
      tail = HW'(tail_sum - (CW+1)'(RATE_FIFO_DEPTH));
    end else begin
      tail = HW'(tail_sum);
    end
  end

  assign head_nxt = (head_q == HW'(RATE_FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign full     = (count_q == CW'(RATE_FIFO_DEPTH));

  tccq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RATE_FIFO_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push && !full),
    .waddr_i (tail),
    .wdata_i ({tags_q, pos_q, tgt_q}),
    .raddr_i (head_q),
    .rdata_o (rd_entry)
  );

  // item fields: no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tags_q <= {gen_tag_i, epoch_tag_i};
      pos_q  <= sample_pos_i;
      tgt_q  <= target_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      count_q    <= '0;
      fvalid_q   <= 1'b0;
      ftags_q    <= '0;
      ftime_q    <= '0;
      ftgt_q     <= '0;
      blk_q      <= '0;
      rdue_q     <= 1'b0;
      fdue_q     <= 1'b0;
      dropped_q  <= 1'b0;
      rtgt_q     <= '0;
      ftgt_out_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        blk_q      <= (func_i == FUNC_CONSUME) ? max_block_i : '0;
        rdue_q     <= 1'b0;
        fdue_q     <= 1'b0;
        dropped_q  <= 1'b0;
        rtgt_q     <= '0;
        ftgt_out_q <= '0;
      end
      if (cmd_i.push) begin
        if (full) begin
          dropped_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.fset) begin
        fvalid_q <= 1'b1;
        ftags_q  <= tags_q;
        ftime_q  <= pos_q;
        ftgt_q   <= tgt_q;
      end
      if (cmd_i.chk) begin
        if (h_miss || h_due) begin
          head_q  <= head_nxt;
          count_q <= count_q - 1'b1;
          if (!h_miss) begin
            rdue_q <= 1'b1;
            rtgt_q <= h_tgt;
          end
        end else if (h_dist < POS_W'(blk_q)) begin
          blk_q <= h_dist[BLK_W-1:0];
        end
      end
      if (cmd_i.frq && fvalid_q) begin
        if (ftags_q != tags_q) begin
          fvalid_q <= 1'b0;
        end else if (ftime_q <= pos_q) begin
          fdue_q     <= 1'b1;
          ftgt_out_q <= ftgt_q;
          fvalid_q   <= 1'b0;
        end else if (f_dist < POS_W'(blk_q)) begin
          blk_q <= f_dist[BLK_W-1:0];
        end
      end
    end
  end

  assign sts_o.empty = (count_q == '0);
  assign sts_o.last  = (count_q == CW'(1));
  assign sts_o.stop  = !h_miss && !h_due;

  assign cnt_ext = (CW+PEND_W)'(count_q);

  assign block_samples_o = blk_q;
  assign rate_due_o      = rdue_q;
  assign rate_target_o   = $signed(rtgt_q);
  assign freq_due_o      = fdue_q;
  assign freq_target_o   = $signed(ftgt_out_q);
  assign rate_pending_o  = (cnt_ext > (CW+PEND_W)'(31)) ? PEND_W'(31) : cnt_ext[PEND_W-1:0];
  assign freq_pending_o  = fvalid_q;
  assign push_dropped_o  = dropped_q;

endmodule

// ----- src/timed_correction_command_queue.sv -----
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ------------------------------------------
// command   in         start_i & !busy_o      func, gen/epoch tag, sample_pos, target,
//                                             max_block
// result    out        done_o (one cycle)     block_samples, due flags/targets,
//                                             pending counts, push_dropped
//
// Push or frequency replace runs its action state, then done_o; an unused selector goes
// straight to done_o. Consume walks the FIFO head, at most depth entries (one RAM read,
// one compare per entry, registered read port sets the pace), then the frequency slot.
// busy_o stays high until the done_o cycle ends; next item after that.
// Reset (rst_ni, async low) empties the FIFO and clears the frequency slot.
// The receiver cannot stall: done_o is shown for exactly one cycle; result regs hold until the next accept.
module timed_correction_command_queue #(
  parameter int unsigned RATE_FIFO_DEPTH = tccq_pkg::RATE_FIFO_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [tccq_pkg::FUNC_W-1:0]        func_i,
  input  logic [tccq_pkg::TAG_W-1:0]         gen_tag_i,
  input  logic [tccq_pkg::TAG_W-1:0]         epoch_tag_i,
  input  logic [tccq_pkg::POS_W-1:0]         sample_pos_i,
  input  logic signed [tccq_pkg::TGT_W-1:0]  target_value_i,
  input  logic [tccq_pkg::BLK_W-1:0]         max_block_i,
  output logic                               done_o,
  output logic [tccq_pkg::BLK_W-1:0]         block_samples_o,
  output logic                               rate_due_o,
  output logic signed [tccq_pkg::TGT_W-1:0]  rate_target_o,
  output logic                               freq_due_o,
  output logic signed [tccq_pkg::TGT_W-1:0]  freq_target_o,
  output logic [tccq_pkg::PEND_W-1:0]        rate_pending_o,
  output logic                               freq_pending_o,
  output logic                               push_dropped_o
);
  import tccq_pkg::*;

  cmd_t cmd;  // controller -> datapath strobes
  sts_t sts;  // FIFO occupancy and head decision back to controller

  // Sequencer: decodes func at accept; for consume walks the FIFO head one entry per
  // read/check pair, then the frequency slot; then strobes the result.
  tccq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Datapath: FIFO RAM with head/count pointers, frequency slot, result regs.
  tccq_dp #(
    .RATE_FIFO_DEPTH (RATE_FIFO_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (func_i),
    .gen_tag_i       (gen_tag_i),
    .epoch_tag_i     (epoch_tag_i),
    .sample_pos_i    (sample_pos_i),
    .target_value_i  (target_value_i),
    .max_block_i     (max_block_i),
    .block_samples_o (block_samples_o),
    .rate_due_o      (rate_due_o),
    .rate_target_o   (rate_target_o),
    .freq_due_o      (freq_due_o),
    .freq_target_o   (freq_target_o),
    .rate_pending_o  (rate_pending_o),
    .freq_pending_o  (freq_pending_o),
    .push_dropped_o  (push_dropped_o)
  );

endmodule
